### rtl/core/adpcm_stream_decoder_assert.svh
// Assertion macros for the ADPCM stream decoder.
`ifndef ADPCM_STREAM_DECODER_ASSERT_SVH
`define ADPCM_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ADSD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define ADSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/adsd_pkg.sv
// Shared types, codes and tables of the ADPCM stream decoder.
package adsd_pkg;

	// input operation codes
	typedef enum logic [1:0] {
		OP_DATA      = 2'd0,
		OP_RESET_PIN = 2'd1,
		OP_START_PIN = 2'd2,
		OP_SPARE     = 2'd3
	} op_t;

	// result kinds
	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_SILENCE = 2'd1,
		KIND_REFUSED = 2'd2,
		KIND_PIN_ACK = 2'd3
	} kind_t;

	// header byte type, top two bits
	typedef enum logic [1:0] {
		HDR_SILENCE = 2'd0,
		HDR_BLOCK   = 2'd1,
		HDR_COUNT   = 2'd2,
		HDR_NOP     = 2'd3
	} hdr_t;

	// port phase, one-hot
	typedef enum logic [3:0] {
		PH_RESET = 4'b0001,
		PH_START = 4'b0010,
		PH_HDR   = 4'b0100,
		PH_COUNT = 4'b1000
	} phase_t;

	// accepted input word
	typedef struct packed {
		op_t        operation;
		logic [7:0] data_byte;
		logic       pin_level;
	} in_word_t;

	// result word before output scaling
	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] acc;
		logic [14:0]        duration;
		logic               idle;
		logic               last;
	} res_word_t;

	localparam logic signed [26:0] OUT_MAX = 27'sd16383;
	localparam logic signed [26:0] OUT_MIN = -27'sd16384;
	localparam logic [8:0]         BLOCK_NIBBLES = 9'd256;

	// delta magnitude by step index and nibble magnitude
	localparam logic [7:0] DELTA_MAG [16][8] = '{
		'{8'd0, 8'd0,  8'd1,  8'd2,  8'd3,  8'd5,   8'd7,   8'd10},
		'{8'd0, 8'd1,  8'd2,  8'd3,  8'd4,  8'd6,   8'd8,   8'd13},
		'{8'd0, 8'd1,  8'd2,  8'd4,  8'd5,  8'd7,   8'd10,  8'd15},
		'{8'd0, 8'd1,  8'd3,  8'd4,  8'd6,  8'd9,   8'd13,  8'd19},
		'{8'd0, 8'd2,  8'd3,  8'd5,  8'd8,  8'd11,  8'd15,  8'd23},
		'{8'd0, 8'd2,  8'd4,  8'd7,  8'd10, 8'd14,  8'd19,  8'd29},
		'{8'd0, 8'd3,  8'd5,  8'd8,  8'd12, 8'd16,  8'd22,  8'd33},
		'{8'd1, 8'd4,  8'd7,  8'd10, 8'd15, 8'd20,  8'd29,  8'd43},
		'{8'd1, 8'd4,  8'd8,  8'd13, 8'd18, 8'd25,  8'd35,  8'd53},
		'{8'd1, 8'd6,  8'd10, 8'd16, 8'd22, 8'd31,  8'd43,  8'd64},
		'{8'd2, 8'd7,  8'd12, 8'd19, 8'd27, 8'd37,  8'd51,  8'd76},
		'{8'd2, 8'd9,  8'd16, 8'd24, 8'd34, 8'd46,  8'd64,  8'd96},
		'{8'd3, 8'd11, 8'd19, 8'd29, 8'd41, 8'd57,  8'd79,  8'd117},
		'{8'd4, 8'd13, 8'd24, 8'd36, 8'd50, 8'd69,  8'd96,  8'd143},
		'{8'd4, 8'd16, 8'd29, 8'd44, 8'd62, 8'd85,  8'd118, 8'd175},
		'{8'd6, 8'd20, 8'd36, 8'd54, 8'd76, 8'd104, 8'd144, 8'd214}
	};

	// step index adaptation by nibble magnitude
	localparam logic signed [2:0] INDEX_ADAPT [8] = '{
		-3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd1, 3'sd2, 3'sd2, 3'sd3
	};

endpackage

### rtl/core/adsd_in_reg.sv
// Input register stage: holds one accepted word until the decoder consumes it.
module adsd_in_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  adsd_pkg::in_word_t in_word,
	input  logic               consume,
	output logic               valid_s1,
	output adsd_pkg::in_word_t word_s1
);

	// stall while the held word is not being consumed
	assign in_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

endmodule

### rtl/core/adsd_decode.sv
// Decode stage: port phase machine, nibble decode and the result register.
module adsd_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  adsd_pkg::in_word_t  word_s1,
	output logic                consume,
	input  logic                out_ready,
	output logic                valid_s2,
	output adsd_pkg::res_word_t res_s2
);

	adsd_pkg::phase_t   phase_q, phase_n;
	logic signed [15:0] acc_q, acc_n;
	logic [3:0]         step_q, step_n;
	logic [8:0]         left_q, left_n;
	logic [6:0]         rate_q, rate_n;
	logic               start_q, start_n;
	logic               nib_q, nib_n;

	logic               ready_s2;
	logic               fire;
	logic               res_en;
	logic               keep;
	adsd_pkg::res_word_t res;

	// nibble decode datapath
	logic [3:0]         nib;
	logic [7:0]         delta;
	logic signed [16:0] acc_x, delta_x, sum;
	logic signed [15:0] acc_dec;
	logic signed [5:0]  step_sum;
	logic [3:0]         step_dec;

	assign ready_s2 = !valid_s2 || out_ready;
	assign fire     = valid_s1 && ready_s2;
	assign consume  = fire && !keep;

	assign nib     = nib_q ? word_s1.data_byte[3:0] : word_s1.data_byte[7:4];
	assign delta   = adsd_pkg::DELTA_MAG[step_q][nib[2:0]];
	assign acc_x   = {acc_q[15], acc_q};
	assign delta_x = $signed({9'd0, delta});
	assign sum     = nib[3] ? (acc_x - delta_x) : (acc_x + delta_x);

	// saturate to 16 bits
	always_comb begin
		if (sum[16] != sum[15]) begin
			acc_dec = sum[16] ? 16'sh8000 : 16'sh7fff;
		end else begin
			acc_dec = sum[15:0];
		end
	end

	// adapt step index, clamp to 0..15
	assign step_sum = $signed({2'b00, step_q}) +
		$signed({{3{adsd_pkg::INDEX_ADAPT[nib[2:0]][2]}}, adsd_pkg::INDEX_ADAPT[nib[2:0]]});
	always_comb begin
		if (step_sum[5]) begin
			step_dec = 4'd0;
		end else if (step_sum[4]) begin
			step_dec = 4'd15;
		end else begin
			step_dec = step_sum[3:0];
		end
	end

	// next state and result for the word in s1
	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		step_n   = step_q;
		left_n   = left_q;
		rate_n   = rate_q;
		start_n  = start_q;
		nib_n    = 1'b0;
		keep     = 1'b0;
		res_en   = 1'b0;
		res.kind     = adsd_pkg::KIND_PIN_ACK;
		res.acc      = 16'sd0;
		res.duration = 15'd0;
		res.idle     = 1'b0;
		res.last     = 1'b1;
		case (word_s1.operation)
			adsd_pkg::OP_RESET_PIN: begin
				if (!word_s1.pin_level) begin
					phase_n = adsd_pkg::PH_RESET;
					acc_n   = 16'sd0;
					step_n  = 4'd0;
					left_n  = 9'd0;
				end else if (phase_q == adsd_pkg::PH_RESET) begin
					phase_n = adsd_pkg::PH_START;
				end
				res_en = 1'b1;
			end
			adsd_pkg::OP_START_PIN: begin
				start_n = word_s1.pin_level;
				res_en  = 1'b1;
			end
			adsd_pkg::OP_SPARE: begin
				res_en = 1'b1;
			end
			adsd_pkg::OP_DATA: begin
				if (left_q != 9'd0) begin
					// one nibble per cycle while the result register can take it, high nibble first
					left_n       = left_q - 9'd1;
					acc_n        = acc_dec;
					step_n       = step_dec;
					res_en       = 1'b1;
					res.kind     = adsd_pkg::KIND_SAMPLE;
					res.acc      = acc_dec;
					res.duration = {8'd0, rate_q};
					if (!nib_q && left_n != 9'd0) begin
						res.last = 1'b0;
						keep     = 1'b1;
						nib_n    = 1'b1;
					end
				end else if (phase_q == adsd_pkg::PH_RESET ||
						(phase_q == adsd_pkg::PH_START && !start_q)) begin
					res_en   = 1'b1;
					res.kind = adsd_pkg::KIND_REFUSED;
				end else if (phase_q == adsd_pkg::PH_COUNT) begin
					left_n  = {1'b0, word_s1.data_byte} + 9'd1;
					phase_n = adsd_pkg::PH_HDR;
				end else if (phase_q == adsd_pkg::PH_START && word_s1.data_byte == 8'd0) begin
					// leading zero byte dropped
				end else begin
					// header byte
					phase_n = adsd_pkg::PH_HDR;
					left_n  = 9'd0;
					rate_n  = 7'd0;
					if (word_s1.data_byte == 8'd0) begin
						phase_n = adsd_pkg::PH_START;
					end else begin
						case (word_s1.data_byte[7:6])
							adsd_pkg::HDR_SILENCE: begin
								acc_n        = 16'sd0;
								res_en       = 1'b1;
								res.kind     = adsd_pkg::KIND_SILENCE;
								// duration (n+1)*256, n the low six header bits
								res.duration = {({1'b0, word_s1.data_byte[5:0]} + 7'd1),
									8'd0};
							end
							adsd_pkg::HDR_BLOCK: begin
								rate_n = {1'b0, word_s1.data_byte[5:0]} + 7'd1;
								left_n = adsd_pkg::BLOCK_NIBBLES;
							end
							adsd_pkg::HDR_COUNT: begin
								rate_n  = {1'b0, word_s1.data_byte[5:0]} + 7'd1;
								phase_n = adsd_pkg::PH_COUNT;
							end
							default: begin
							end
						endcase
					end
				end
			end
			default: begin
				res_en = 1'b1;
			end
		endcase
		res.idle = phase_n inside {adsd_pkg::PH_RESET, adsd_pkg::PH_START};
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= adsd_pkg::PH_RESET;
			acc_q   <= 16'sd0;
			step_q  <= 4'd0;
			left_q  <= 9'd0;
			rate_q  <= 7'd0;
			start_q <= 1'b0;
			nib_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			step_q  <= step_n;
			left_q  <= left_n;
			rate_q  <= rate_n;
			start_q <= start_n;
			nib_q   <= nib_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= fire && res_en;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_en) begin
			res_s2 <= res;
		end
	end

endmodule

### rtl/core/adsd_out_stage.sv
// Output stage: gain scaling, limiting and the output word register.
module adsd_out_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          gain,
	input  logic                valid_s2,
	input  adsd_pkg::res_word_t res_s2,
	output logic                out_ready,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          kind,
	output logic signed [14:0]  sample_value,
	output logic [14:0]         duration,
	output logic                idle,
	output logic                last
);

	logic signed [26:0] prod;
	logic signed [14:0] scaled;

	assign out_ready = !out_valid || !out_stall;

	// sample times four times gain, limited to 15 bits
	assign prod = res_s2.acc * $signed({1'b0, gain, 2'b00});
	always_comb begin
		if (prod > adsd_pkg::OUT_MAX) begin
			scaled = adsd_pkg::OUT_MAX[14:0];
		end else if (prod < adsd_pkg::OUT_MIN) begin
			scaled = adsd_pkg::OUT_MIN[14:0];
		end else begin
			scaled = prod[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && valid_s2) begin
			kind         <= res_s2.kind;
			sample_value <= scaled;
			duration     <= res_s2.duration;
			idle         <= res_s2.idle;
			last         <= res_s2.last;
		end
	end

endmodule

### rtl/core/adpcm_stream_decoder.sv
// ADPCM stream decoder top level: three register stages, input to output word.
// A word passes from the input register through the result register to the
// output register. One input word per cycle while no stage stalls; a byte with
// two nibbles stays in decode for both, one nibble per cycle via the shared adder.
// Reset (arst_n low, asynchronous): phase reset, accumulator, step index,
// nibble count, rate, start level and gain cleared; all stages empty.
`include "adpcm_stream_decoder_assert.svh"

module adpcm_stream_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          operation,
	input  logic [7:0]          data_byte,
	input  logic                pin_level,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          kind,
	output logic signed [14:0]  sample_value,
	output logic [14:0]         duration,
	output logic                idle,
	output logic                last,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data
);

	adsd_pkg::in_word_t  in_word;
	adsd_pkg::in_word_t  word_s1;
	adsd_pkg::res_word_t res_s2;
	logic                valid_s1;
	logic                valid_s2;
	logic                consume;
	logic                out_ready;
	logic [7:0]          gain_q;

	assign in_word.operation = adsd_pkg::op_t'(operation);
	assign in_word.data_byte = data_byte;
	assign in_word.pin_level = pin_level;

	// gain register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= 8'd0;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	adsd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.consume  (consume),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	adsd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.word_s1   (word_s1),
		.consume   (consume),
		.out_ready (out_ready),
		.valid_s2  (valid_s2),
		.res_s2    (res_s2)
	);

	adsd_out_stage u_out_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.gain         (gain_q),
		.valid_s2     (valid_s2),
		.res_s2       (res_s2),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.sample_value (sample_value),
		.duration     (duration),
		.idle         (idle),
		.last         (last)
	);

	// checks
	`ADSD_ASSERT_NOW(a_value_only_on_sample, out_valid && kind != adsd_pkg::KIND_SAMPLE, sample_value == 15'sd0, "nonzero value on a non-sample word")
	`ADSD_ASSERT_NOW(a_refused_when_idle, out_valid && kind == adsd_pkg::KIND_REFUSED, idle, "byte refused while not idle")
	`ADSD_ASSERT_NEXT(a_second_nibble_follows, out_valid && !last && !out_stall, out_valid && kind == adsd_pkg::KIND_SAMPLE, "second nibble did not follow the first")

endmodule
